[src/tsom_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register codes and fixed-point constants of the tone/saw oscillator mixer.
package tsom_pkg;

  // Sample format: signed Q1.23
  localparam int SAMPLE_W    = 24;
  localparam int SAMPLE_FRAC = SAMPLE_W - 1;

  // Generated sample after alignment to sample fraction bits, with headroom
  localparam int GEN_W = SAMPLE_W + 2;

  // Register fraction bits
  localparam int COEF_FRAC   = 30;
  localparam int GAIN_FRAC   = 20;
  localparam int OFFSET_FRAC = 23;

  // Defaults for the top-level parameters
  localparam int STATE_WIDTH_DEF = 32;
  localparam int MID_DEPTH_DEF   = 2;
  localparam int OUT_DEPTH_DEF   = 4;

  // Configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam logic [23:0] GAIN_RESET = 24'd1048576;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_COEF_A      = 3'd1,
    REG_COEF_B      = 3'd2,
    REG_SAW_INC     = 3'd3,
    REG_GAIN        = 3'd4,
    REG_OFFSET      = 3'd5,
    REG_INIT_FIRST  = 3'd6,
    REG_INIT_SECOND = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    MODE_TONE = 1'b0,
    MODE_SAW  = 1'b1
  } osc_mode_t;

  typedef struct packed {
    osc_mode_t          mode;
    logic signed [31:0] coef_a;
    logic signed [30:0] coef_b;
    logic        [30:0] saw_increment;
    logic        [23:0] gain;
    logic signed [23:0] offset;
    logic signed [31:0] init_first;
    logic signed [31:0] init_second;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] src_left;
    logic signed [SAMPLE_W-1:0] src_right;
    logic                       restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_item_t;

  // Request passed from the oscillator front to the mixing back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] src_left;
    logic signed [SAMPLE_W-1:0] src_right;
    logic signed [GEN_W-1:0]    gen;
  } mid_item_t;

endpackage

[src/tsom_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file of the tone/saw oscillator mixer.
module tsom_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [tsom_pkg::CFG_INDEX_W-1:0] index,
  input  logic [tsom_pkg::CFG_DATA_W-1:0]  data,
  output tsom_pkg::cfg_regs_t              regs
);
  import tsom_pkg::*;

  // Register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{mode: MODE_TONE, gain: GAIN_RESET, default: '0};
    end else if (we) begin
      unique case (cfg_reg_t'(index))
        REG_MODE:        regs.mode          <= osc_mode_t'(data[0]);
        REG_COEF_A:      regs.coef_a        <= data;
        REG_COEF_B:      regs.coef_b        <= data[30:0];
        REG_SAW_INC:     regs.saw_increment <= data[30:0];
        REG_GAIN:        regs.gain          <= data[23:0];
        REG_OFFSET:      regs.offset        <= data[23:0];
        REG_INIT_FIRST:  regs.init_first    <= data;
        REG_INIT_SECOND: regs.init_second   <= data;
        default: ;
      endcase
    end
  end

endmodule

[src/tsom_fifo.sv]
`timescale 1ns / 1ps
// Small register-based first-in first-out queue.
module tsom_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[src/tsom_front.sv]
`timescale 1ns / 1ps
// Oscillator front: takes frames, steps the tone/saw state and emits the generated sample.
module tsom_front #(
  parameter int STATE_WIDTH = tsom_pkg::STATE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tsom_pkg::cfg_regs_t cfg,
  input  logic                take,
  input  tsom_pkg::in_item_t  item,
  output tsom_pkg::mid_item_t mid
);
  import tsom_pkg::*;

  // State is Q2.F, stored one bit wider since a rounded restart can reach +2^(W-1)
  localparam int F  = STATE_WIDTH - 2;
  localparam int XW = STATE_WIDTH + 1;
  localparam int WW = STATE_WIDTH + 52;

  // Alignment between Q2.30 registers and the state format
  localparam int UP  = (F >= COEF_FRAC) ? F - COEF_FRAC : 0;
  localparam int DN  = (F < COEF_FRAC) ? COEF_FRAC - F : 0;
  localparam int DN1 = (DN > 0) ? DN - 1 : 0;

  // Alignment of the state to the sample format
  localparam int G_UP  = (F < SAMPLE_FRAC) ? SAMPLE_FRAC - F : 0;
  localparam int G_DN  = (F > SAMPLE_FRAC) ? F - SAMPLE_FRAC : 0;
  localparam int G_DN1 = (G_DN > 0) ? G_DN - 1 : 0;

  localparam logic signed [WW-1:0] ONE_W  = 1;
  localparam logic signed [WW-1:0] SMAX   = (ONE_W <<< (STATE_WIDTH - 1)) - ONE_W;
  localparam logic signed [WW-1:0] SMIN   = -(ONE_W <<< (STATE_WIDTH - 1));
  localparam logic signed [WW-1:0] UNITY  = ONE_W <<< F;
  localparam logic signed [WW-1:0] HALF_C = ONE_W <<< (COEF_FRAC - 1);
  localparam logic signed [WW-1:0] HALF_D = ONE_W <<< DN1;
  localparam logic signed [WW-1:0] HALF_G = ONE_W <<< G_DN1;

  logic signed [XW-1:0]    first_value;
  logic signed [XW-1:0]    second_value;
  logic signed [XW-1:0]    first_ld;
  logic signed [XW-1:0]    second_ld;
  logic signed [XW+31:0]   prod_a;
  logic signed [XW+30:0]   prod_b;
  logic signed [WW-1:0]    acc;
  logic signed [WW-1:0]    acc_rnd;
  logic signed [WW-1:0]    acc_al;
  logic signed [XW-1:0]    tone_next;
  logic signed [WW-1:0]    inc_al;
  logic signed [WW-1:0]    saw_sum;
  logic signed [XW-1:0]    saw_next;
  logic signed [WW-1:0]    gen_w;

  // Restart value: Q2.30 register aligned to the state format, rounding half up
  function automatic logic signed [XW-1:0] load_align(input logic signed [31:0] v);
    logic signed [32:0] w;
    begin
      w = 33'(v) + (33'sd1 <<< DN1);
      if (DN == 0) begin
        return XW'(v) <<< UP;
      end
      return XW'(w >>> DN);
    end
  endfunction

  // State seen by this step, after an optional restart
  assign first_ld  = item.restart ? load_align(cfg.init_first) : first_value;
  assign second_ld = item.restart ? load_align(cfg.init_second) : second_value;

  // Resonator: a*first + b*second, rounded to 30 fraction bits, realigned, saturated
  always_comb begin
    prod_a  = $signed(cfg.coef_a) * first_ld;
    prod_b  = $signed(cfg.coef_b) * second_ld;
    acc     = WW'(prod_a) + WW'(prod_b);
    acc_rnd = (acc + HALF_C) >>> COEF_FRAC;
    if (DN == 0) begin
      acc_al = acc_rnd <<< UP;
    end else begin
      acc_al = (acc_rnd + HALF_D) >>> DN;
    end
    if (acc_al > SMAX) begin
      tone_next = XW'(SMAX);
    end else if (acc_al < SMIN) begin
      tone_next = XW'(SMIN);
    end else begin
      tone_next = XW'(acc_al);
    end
  end

  // Sawtooth: add the aligned increment, wrap to -1.0 strictly above +1.0
  always_comb begin
    if (DN == 0) begin
      inc_al = WW'($signed({1'b0, cfg.saw_increment})) <<< UP;
    end else begin
      inc_al = (WW'($signed({1'b0, cfg.saw_increment})) + HALF_D) >>> DN;
    end
    saw_sum  = WW'(first_ld) + inc_al;
    saw_next = (saw_sum > UNITY) ? XW'(-UNITY) : XW'(saw_sum);
  end

  // Generated sample: pre-update first state in sample fraction bits
  always_comb begin
    if (G_DN == 0) begin
      gen_w = WW'(first_ld) <<< G_UP;
    end else begin
      gen_w = (WW'(first_ld) + HALF_G) >>> G_DN;
    end
  end

  // Request toward the back
  always_comb begin
    mid.src_left  = item.src_left;
    mid.src_right = item.src_right;
    mid.gen       = GEN_W'(gen_w);
  end

  // Oscillator state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_value  <= '0;
      second_value <= '0;
    end else if (take) begin
      if (cfg.mode == MODE_TONE) begin
        first_value  <= tone_next;
        second_value <= first_ld;
      end else begin
        first_value  <= saw_next;
        second_value <= second_ld;
      end
    end
  end

  // Tone step shifts the old first state into the second
  a_tone_shift: assert property (@(posedge clk) disable iff (rst)
    take && cfg.mode == MODE_TONE |=> second_value == $past(first_ld))
    else $error("tone step did not shift first state into second");

  // Saw never leaves the first state above +1.0
  a_saw_bound: assert property (@(posedge clk) disable iff (rst)
    take && cfg.mode == MODE_SAW |=> WW'(first_value) <= UNITY)
    else $error("saw state above unity after a step");

endmodule

[src/tsom_back.sv]
`timescale 1ns / 1ps
// Mixing back: scales the generated sample by gain, adds source and offset, saturates.
module tsom_back #(
  parameter int OUT_DEPTH = tsom_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tsom_pkg::cfg_regs_t cfg,
  input  logic                mid_empty,
  input  tsom_pkg::mid_item_t mid,
  output logic                mid_pop,
  output logic                empty,
  input  logic                pop,
  output tsom_pkg::out_item_t result
);
  import tsom_pkg::*;

  localparam int OCW    = $clog2(OUT_DEPTH + 1);
  localparam int PROD_W = GEN_W + 25;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [PROD_W-1:0] ONE_P  = 1;
  localparam logic signed [PROD_W-1:0] HALF_M = ONE_P <<< (GAIN_FRAC - 1);
  localparam logic signed [SUM_W-1:0]  ONE_S  = 1;
  localparam logic signed [SUM_W-1:0]  OMAX   = (ONE_S <<< (SAMPLE_W - 1)) - ONE_S;
  localparam logic signed [SUM_W-1:0]  OMIN   = -(ONE_S <<< (SAMPLE_W - 1));

  logic                        s1_valid;
  logic signed [SAMPLE_W-1:0]  s1_left;
  logic signed [SAMPLE_W-1:0]  s1_right;
  logic signed [PROD_W-1:0]    s1_prod;
  logic signed [PROD_W-1:0]    mix;
  logic signed [SUM_W-1:0]     sum_left;
  logic signed [SUM_W-1:0]     sum_right;
  out_item_t                   mixed;
  logic [OCW-1:0]              out_count;
  logic                        out_full;
  logic [OCW:0]                in_flight;

  // Credit: take a request only if the result queue has room for everything in flight
  assign in_flight = (OCW + 1)'(out_count) + (OCW + 1)'(s1_valid);
  assign mid_pop   = !mid_empty && (in_flight < (OCW + 1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= mid_pop;
    end
  end

  // Gain multiply stage
  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_left  <= mid.src_left;
      s1_right <= mid.src_right;
      s1_prod  <= mid.gen * $signed({1'b0, cfg.gain});
    end
  end

  // Round to sample, add source and offset (offset already has sample fraction bits)
  always_comb begin
    mix       = (s1_prod + HALF_M) >>> GAIN_FRAC;
    sum_left  = SUM_W'(s1_left) + SUM_W'(mix) + SUM_W'(cfg.offset);
    sum_right = SUM_W'(s1_right) + SUM_W'(mix) + SUM_W'(cfg.offset);
    if (sum_left > OMAX) begin
      mixed.out_left = SAMPLE_W'(OMAX);
    end else if (sum_left < OMIN) begin
      mixed.out_left = SAMPLE_W'(OMIN);
    end else begin
      mixed.out_left = SAMPLE_W'(sum_left);
    end
    if (sum_right > OMAX) begin
      mixed.out_right = SAMPLE_W'(OMAX);
    end else if (sum_right < OMIN) begin
      mixed.out_right = SAMPLE_W'(OMIN);
    end else begin
      mixed.out_right = SAMPLE_W'(sum_right);
    end
  end

  // Result queue
  tsom_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s1_valid),
    .wdata (mixed),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .count (out_count)
  );

  // Credit scheme keeps the result queue from ever dropping a request
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !out_full)
    else $error("result queue full while a result is written");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= (OCW + 1)'(OUT_DEPTH))
    else $error("more requests in flight than result queue entries");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> !empty)
    else $error("written result not visible");

endmodule

[src/tone_saw_oscillator_mixer_top.sv]
`timescale 1ns / 1ps
// Top level of the tone/saw oscillator mixer.
//
// Mixes a damped-resonator tone or a sawtooth into a stereo stream: each accepted frame
// gets gain times the generated sample plus offset on both channels, saturated to 24 bits.
// One frame is accepted per clock while full is low; the state recursion (two multiplies of the
// 32-bit and 31-bit coefficients by the STATE_WIDTH+1-bit states, rounding and saturation)
// closes in the cycle a frame is accepted. A result passes from its frame through the queue
// between the oscillator and the mixer, the gain multiply register and the result queue before
// it shows on the result ports. Up to MID_DEPTH frames wait ahead of the mixer and up to
// OUT_DEPTH results wait to be popped; full rises when the queue ahead of the mixer fills.
// Configuration registers are written at any clock with cfg_we high and take effect for
// the next frame; they should be changed only while no frame is in flight.
module tone_saw_oscillator_mixer_top #(
  parameter int STATE_WIDTH = tsom_pkg::STATE_WIDTH_DEF,
  parameter int MID_DEPTH   = tsom_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH   = tsom_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  tsom_pkg::in_item_t               src,
  output logic                             empty,
  input  logic                             pop,
  output tsom_pkg::out_item_t              result,
  input  logic                             cfg_we,
  input  logic [tsom_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsom_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tsom_pkg::*;

  cfg_regs_t cfg;
  mid_item_t mid_in;
  mid_item_t mid_out;
  logic      accept;
  logic      mid_empty;
  logic      mid_pop;

  assign accept = push && !full;

  // Configuration registers
  tsom_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .regs  (cfg)
  );

  // Oscillator front
  tsom_front #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (accept),
    .item (src),
    .mid  (mid_in)
  );

  // Queue between front and back
  tsom_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (mid_in),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty),
    .count ()
  );

  // Mixing back
  tsom_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid       (mid_out),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

[bench/tone_saw_oscillator_mixer_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the tone/saw oscillator mixer: directed corners, then random frames.
module tone_saw_oscillator_mixer_top_tb;
  import tsom_pkg::*;

  // Tracks the oscillator state and register copy, and holds the mixed frames still owed
  class mix_scoreboard;
    cfg_regs_t regs;
    longint    first_q;
    longint    second_q;
    out_item_t pending_mix[$];
    int        errors;

    function new();
      regs = '0;
      regs.gain = GAIN_RESET;
      first_q = 0;
      second_q = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_MODE:        regs.mode = osc_mode_t'(data[0]);
        REG_COEF_A:      regs.coef_a = data;
        REG_COEF_B:      regs.coef_b = data[30:0];
        REG_SAW_INC:     regs.saw_increment = data[30:0];
        REG_GAIN:        regs.gain = data[23:0];
        REG_OFFSET:      regs.offset = data[23:0];
        REG_INIT_FIRST:  regs.init_first = data;
        REG_INIT_SECOND: regs.init_second = data;
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // Advances the oscillator by one frame and returns the mixed stereo sample
    function out_item_t mix_frame(in_item_t f);
      out_item_t mixed;
      longint gen, nxt, a, b, h0, l0, h1, l1, acc, one, mixv, offv;
      if (f.restart) begin
        first_q = longint'($signed(regs.init_first));
        second_q = longint'($signed(regs.init_second));
      end
      // sample is the state before the update, rounded from 30 to 23 fraction bits
      gen = (first_q + 64) >>> 7;
      if (regs.mode == MODE_TONE) begin
        a = longint'($signed(regs.coef_a));
        b = longint'($signed(regs.coef_b));
        h0 = first_q >>> 16;
        l0 = first_q - h0 * 65536;
        h1 = second_q >>> 16;
        l1 = second_q - h1 * 65536;
        acc = a * h0 + b * h1 + ((a * l0 + b * l1) >>> 16);
        nxt = clamp((acc + 8192) >>> 14, 32);
        second_q = first_q;
        first_q = nxt;
      end else begin
        // wrap only when strictly above +1.0
        one = longint'(1) << 30;
        nxt = first_q + longint'(regs.saw_increment);
        first_q = (nxt > one) ? -one : nxt;
      end
      mixv = (gen * longint'(regs.gain) + (longint'(1) << 19)) >>> 20;
      offv = longint'($signed(regs.offset));
      acc = clamp(longint'(f.src_left) + mixv + offv, SAMPLE_W);
      mixed.out_left = acc[SAMPLE_W-1:0];
      acc = clamp(longint'(f.src_right) + mixv + offv, SAMPLE_W);
      mixed.out_right = acc[SAMPLE_W-1:0];
      return mixed;
    endfunction

    function void note_frame(in_item_t f);
      pending_mix.push_back(mix_frame(f));
    endfunction

    function void flag(string what, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
      errors++;
      if (errors <= 10)
        $display("%0t: %0s mismatch: expected %0d, got %0d", $time, what,
                 $signed(want), $signed(got));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_mix.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result %h with no frame outstanding", $time, got);
        return;
      end
      want = pending_mix.pop_front();
      if (got.out_left !== want.out_left) flag("out_left", want.out_left, got.out_left);
      if (got.out_right !== want.out_right) flag("out_right", want.out_right, got.out_right);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  in_item_t               src = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  out_item_t              result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  mix_scoreboard sb = new();
  int tx_idle_max = 0;
  int rx_idle_max = 0;

  tone_saw_oscillator_mixer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .src       (src),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #4000000;
    $display("tone_saw_oscillator_mixer_top_tb: errors");
    $finish;
  end

  // Result side: random pop stalls, every popped frame checked in order
  initial begin
    int gap;
    do @(negedge clk); while (rst);
    forever begin
      gap = $urandom_range(0, rx_idle_max);
      repeat (gap) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(result);
    end
  end

  // Register write; only called with no frame in flight
  task automatic set_reg(input cfg_reg_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Present one frame after a random gap and hold it until accepted
  task automatic send_frame(input logic [23:0] left, input logic [23:0] right,
                            input logic restart);
    in_item_t f;
    int gap;
    f.src_left = left;
    f.src_right = right;
    f.restart = restart;
    gap = $urandom_range(0, tx_idle_max);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    src <= f;
    do @(posedge clk); while (full);
    sb.note_frame(f);
  endtask

  // Stop sending and wait for every owed result, plus the pipeline depth
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending_mix.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    int v;
    if ($urandom_range(0, 1) == 1) return $urandom;
    v = $urandom_range(0, 1 << 21) - (1 << 20);
    return v;
  endfunction

  function automatic int rand_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 18;
    endcase
  endfunction

  // New random register set: mostly a stable resonator / audible saw, some raw bits
  task automatic random_setup();
    int r2, amp, v;
    set_reg(REG_MODE, $urandom);
    if ($urandom_range(0, 3) != 0) begin
      r2 = $urandom_range(3 << 28, 1 << 30);
      amp = $urandom_range(0, (1 << 30) + r2 - 1);
      set_reg(REG_COEF_A, ($urandom_range(0, 1) == 1) ? -amp : amp);
      set_reg(REG_COEF_B, -r2);
    end else begin
      set_reg(REG_COEF_A, $urandom);
      set_reg(REG_COEF_B, $urandom);
    end
    case ($urandom_range(0, 3))
      0: set_reg(REG_SAW_INC, $urandom);
      1: set_reg(REG_SAW_INC, $urandom_range(0, 1 << 30));
      default: set_reg(REG_SAW_INC, $urandom_range(0, 1 << 24));
    endcase
    set_reg(REG_GAIN, ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1 << 21));
    v = $urandom_range(0, 1 << 16) - (1 << 15);
    set_reg(REG_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom : v);
    v = $urandom_range(0, 1 << 29) - (1 << 28);
    set_reg(REG_INIT_FIRST, ($urandom_range(0, 3) == 0) ? $urandom : v);
    v = $urandom_range(0, 1 << 29) - (1 << 28);
    set_reg(REG_INIT_SECOND, ($urandom_range(0, 3) == 0) ? $urandom : v);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    tx_idle_max = 3;
    rx_idle_max = 3;

    // Reset registers: generator silent, frames pass through
    send_frame(24'h7FFFFF, 24'h800000, 1'b0);
    send_frame(24'h800000, 24'h7FFFFF, 1'b1);
    wait_drained();

    // Tone overflow upward, out-of-range positive coef_b, mix saturates high
    set_reg(REG_MODE, 32'(MODE_TONE));
    set_reg(REG_COEF_A, 32'h7FFFFFFF);
    set_reg(REG_COEF_B, 32'h3FFFFFFF);
    set_reg(REG_GAIN, 32'h00FFFFFF);
    set_reg(REG_OFFSET, 32'h007FFFFF);
    set_reg(REG_INIT_FIRST, 32'h7FFFFFFF);
    set_reg(REG_INIT_SECOND, 32'h7FFFFFFF);
    send_frame(24'h7FFFFF, 24'h000000, 1'b1);
    repeat (3) send_frame(24'h7FFFFF, 24'h000000, 1'b0);
    wait_drained();

    // Tone overflow downward, most negative coefficients, mix saturates low
    set_reg(REG_COEF_A, 32'h80000000);
    set_reg(REG_COEF_B, 32'h40000000);
    set_reg(REG_OFFSET, 32'h00800000);
    tx_idle_max = 0;
    rx_idle_max = 0;
    send_frame(24'h800000, 24'h000001, 1'b1);
    repeat (3) send_frame(24'h800000, 24'hFFFFFF, 1'b0);
    wait_drained();

    // Saw at a full-scale step: exactly +1.0 is kept, then it wraps to -1.0
    set_reg(REG_MODE, 32'(MODE_SAW));
    set_reg(REG_SAW_INC, 32'h40000000);
    set_reg(REG_INIT_FIRST, 32'h00000000);
    set_reg(REG_GAIN, 32'(GAIN_RESET));
    set_reg(REG_OFFSET, 32'h00000000);
    send_frame(24'h000000, 24'h000000, 1'b1);
    repeat (4) send_frame(24'h000000, 24'h400000, 1'b0);
    wait_drained();

    // Saw with out-of-range step and top start value, zero gain
    set_reg(REG_SAW_INC, 32'hFFFFFFFF);
    set_reg(REG_INIT_FIRST, 32'h7FFFFFFF);
    set_reg(REG_GAIN, 32'h00000000);
    tx_idle_max = 18;
    rx_idle_max = 18;
    send_frame(24'h123456, 24'hABCDEF, 1'b1);
    repeat (2) send_frame(24'h654321, 24'hFEDCBA, 1'b0);
    wait_drained();

    // Saw held at the most negative start value
    set_reg(REG_INIT_FIRST, 32'h80000000);
    set_reg(REG_SAW_INC, 32'h00000000);
    set_reg(REG_GAIN, 32'h00FFFFFF);
    send_frame(24'h000000, 24'h7FFFFF, 1'b1);
    send_frame(24'h800000, 24'h000000, 1'b0);
    wait_drained();

    // Random phases, each with fresh registers and a restart on the first frame
    for (int phase = 0; phase < 8; phase++) begin
      random_setup();
      for (int k = 0; k < 50; k++) begin
        if (k % 25 == 0) begin
          tx_idle_max = rand_idle();
          rx_idle_max = rand_idle();
        end
        // occasional hold-off until the result queue runs dry
        if ($urandom_range(0, 59) == 0) wait_drained();
        send_frame(rand_sample(), rand_sample(), (k == 0) || ($urandom_range(0, 24) == 0));
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_mix.size() == 0) begin
      $display("tone_saw_oscillator_mixer_top_tb: clean");
    end else begin
      $display("tone_saw_oscillator_mixer_top_tb: errors");
    end
    $finish;
  end

endmodule
